// ===== hdl/point_in_triangle_mesh_test_core_macros.svh =====
// ----------------------------------------------------------------------------
// point_in_triangle_mesh_test_core_macros
// assertion helpers for the floor test sequencer
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_MESH_TEST_CORE_MACROS_SVH
`define POINT_IN_TRIANGLE_MESH_TEST_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PITM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PITM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pitm_pkg.sv =====
// ----------------------------------------------------------------------------
// pitm_pkg
// shared types, widths and codes of the floor triangle point test
// ----------------------------------------------------------------------------
package pitm_pkg;

  // table geometry
  localparam int ADDR_W        = 8;
  localparam int MAX_TRIANGLES = 1 << ADDR_W;
  localparam int CNT_W         = ADDR_W + 1;
  localparam int SLOT_W        = 8;

  // coordinate and arithmetic widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int NG_W       = SUM_W + 2;

  // stream widths
  localparam int IN_DATA_W  = 8 * ((SLOT_W + 8 * COORD_BITS + 7) / 8);
  localparam int OUT_DATA_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_X_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_X_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_Y_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_Y_MAX     = 3'd4;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // register reset values
  localparam coord_t SAFE_X_MIN_RST = 16'sd160;
  localparam coord_t SAFE_X_MAX_RST = 16'sd544;
  localparam coord_t SAFE_Y_MIN_RST = 16'sd288;
  localparam coord_t SAFE_Y_MAX_RST = 16'sd720;

  // one input transaction payload, slot in the lowest bits
  typedef struct packed {
    coord_t              query_y;
    coord_t              query_x;
    coord_t              corner_c_y;
    coord_t              corner_c_x;
    coord_t              corner_b_y;
    coord_t              corner_b_x;
    coord_t              corner_a_y;
    coord_t              corner_a_x;
    logic [SLOT_W-1:0]   slot;
  } pitm_item_t;

  // one stored triangle
  typedef struct packed {
    coord_t cy;
    coord_t cx;
    coord_t by;
    coord_t bx;
    coord_t ay;
    coord_t ax;
  } pitm_tri_t;

  // controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic              query_start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } pitm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } pitm_status_t;

endpackage

// ===== hdl/pitm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pitm_ctrl
// sequencer: takes transactions, walks the triangle table, hands off results
// ----------------------------------------------------------------------------
`include "point_in_triangle_mesh_test_core_macros.svh"

module pitm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_opcode,
  output logic                       in_tready,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  input  logic [pitm_pkg::CNT_W-1:0] triangle_count,
  input  pitm_pkg::pitm_status_t     status,
  output pitm_pkg::pitm_cmd_t        cmd
);
  import pitm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] n_sat;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  // searched count saturates at the table depth
  assign n_sat = (triangle_count > CNT_W'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES)
                                                          : triangle_count;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            cnt_nxt = '0;
            state_nxt = (n_sat == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt_r[ADDR_W-1:0];
        cnt_nxt     = cnt_inc;
        if (cnt_inc == n_sat) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy && out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `PITM_ASSERT_NOW(a_load_after_drain, clk, rst_n, cmd.out_load, !status.busy, "result taken before pipeline drained")
  `PITM_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == ST_SCAN, cnt_r < n_sat, "scan address past searched count")
  `PITM_ASSERT_NEXT(a_query_leaves_idle, clk, rst_n, accept && in_opcode == OP_QUERY, state_r != ST_IDLE, "query did not start a search")
  `PITM_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, accept && in_opcode == OP_LOAD, state_r == ST_IDLE && !out_tvalid || state_r == ST_IDLE, "load left idle")

endmodule

// ===== hdl/pitm_dp.sv =====
// ----------------------------------------------------------------------------
// pitm_dp
// triangle memory, four-stage inside test pipeline and result register
// ----------------------------------------------------------------------------
module pitm_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pitm_pkg::pitm_item_t   item,
  input  pitm_pkg::coord_t       safe_x_min,
  input  pitm_pkg::coord_t       safe_x_max,
  input  pitm_pkg::coord_t       safe_y_min,
  input  pitm_pkg::coord_t       safe_y_max,
  input  pitm_pkg::pitm_cmd_t    cmd,
  output pitm_pkg::pitm_status_t status,
  output logic                   inside_floor,
  output logic                   wall_hit
);
  import pitm_pkg::*;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [NG_W-1:0]   ng_t;

  function automatic diff_t sub(input coord_t a, input coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  pitm_tri_t mem [MAX_TRIANGLES];
  pitm_tri_t rd_r;
  logic      vr_r, v1_r, v2_r, v3_r;
  coord_t    qx_r, qy_r;
  diff_t     e1_r, e2_r, e3_r, e4_r, f_r, dx_r, dy_r;
  prod_t     pd1_r, pd2_r, pa1_r, pa2_r, pb1_r, pb2_r;
  sum_t      d_r, na_r, nb_r;
  ng_t       ng;
  logic      hit;
  logic      acc_r;
  logic      inside_r, wall_r;
  logic      safe;

  // triangle memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[item.slot] <= '{cy: item.corner_c_y, cx: item.corner_c_x,
                          by: item.corner_b_y, bx: item.corner_b_x,
                          ay: item.corner_a_y, ax: item.corner_a_x};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[cmd.rd_addr];
    end
  end

  // query point
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx_r <= item.query_x;
      qy_r <= item.query_y;
    end
  end

  // stage 1: edge and offset differences
  always_ff @(posedge clk) begin
    e1_r <= sub(rd_r.by, rd_r.cy);
    e2_r <= sub(rd_r.cx, rd_r.bx);
    e3_r <= sub(rd_r.cy, rd_r.ay);
    e4_r <= sub(rd_r.ax, rd_r.cx);
    f_r  <= sub(rd_r.ay, rd_r.cy);
    dx_r <= sub(qx_r, rd_r.cx);
    dy_r <= sub(qy_r, rd_r.cy);
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    pd1_r <= e1_r * e4_r;
    pd2_r <= e2_r * f_r;
    pa1_r <= e1_r * dx_r;
    pa2_r <= e2_r * dy_r;
    pb1_r <= e3_r * dx_r;
    pb2_r <= e4_r * dy_r;
  end

  // stage 3: denominator and numerators
  always_ff @(posedge clk) begin
    d_r  <= SUM_W'(pd1_r) + SUM_W'(pd2_r);
    na_r <= SUM_W'(pa1_r) + SUM_W'(pa2_r);
    nb_r <= SUM_W'(pb1_r) + SUM_W'(pb2_r);
  end

  // stage 4: third weight and strict sign match
  assign ng  = NG_W'(d_r) - NG_W'(na_r) - NG_W'(nb_r);
  assign hit = ((d_r > 0) && (na_r > 0) && (nb_r > 0) && (ng > 0)) ||
               ((d_r < 0) && (na_r < 0) && (nb_r < 0) && (ng < 0));

  // stage valid bits and hit accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      acc_r <= 1'b0;
    end else begin
      vr_r <= cmd.rd_en;
      v1_r <= vr_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.query_start) begin
        acc_r <= 1'b0;
      end else if (v3_r && hit) begin
        acc_r <= 1'b1;
      end
    end
  end

  assign status.busy = vr_r | v1_r | v2_r | v3_r;

  // safe rectangle, bounds exclusive
  assign safe = (qx_r > safe_x_min) && (qx_r < safe_x_max) &&
                (qy_r > safe_y_min) && (qy_r < safe_y_max);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      inside_r <= acc_r;
      wall_r   <= ~safe & ~acc_r;
    end
  end

  assign inside_floor = inside_r;
  assign wall_hit     = wall_r;

endmodule

// ===== hdl/point_in_triangle_mesh_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_mesh_test_core
// floor triangle table with strict point-inside test and wall flag
// ----------------------------------------------------------------------------
// load: one table write, ready again the next cycle, no result transaction
// query: the input stays not ready until the result is loaded, so one query
//   is searched at a time over n = min(count, 256) triangles, none if empty
// the search reads one triangle a cycle from the single-read-port table, then
//   four pipeline stages drain; a result still held on out delays the next one
// reset: control, valid bits and config registers reset, table is not cleared
module point_in_triangle_mesh_test_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // slot, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // corner_c_x, corner_c_y, query_x, query_y
  input  logic [pitm_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [0:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // inside_floor, wall_hit, zero padding
  output logic [pitm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [pitm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pitm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pitm_pkg::*;

  pitm_item_t       item;
  pitm_cmd_t        cmd;
  pitm_status_t     status;
  logic [CNT_W-1:0] count_r;
  coord_t           sx_min_r, sx_max_r, sy_min_r, sy_max_r;
  logic             inside_floor, wall_hit;

  assign item = pitm_item_t'(in_tdata);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sx_min_r <= SAFE_X_MIN_RST;
      sx_max_r <= SAFE_X_MAX_RST;
      sy_min_r <= SAFE_Y_MIN_RST;
      sy_max_r <= SAFE_Y_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIANGLE_COUNT: count_r  <= cfg_wdata[CNT_W-1:0];
        REG_SAFE_X_MIN:     sx_min_r <= coord_t'(cfg_wdata);
        REG_SAFE_X_MAX:     sx_max_r <= coord_t'(cfg_wdata);
        REG_SAFE_Y_MIN:     sy_min_r <= coord_t'(cfg_wdata);
        REG_SAFE_Y_MAX:     sy_max_r <= coord_t'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // sequencer
  pitm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_opcode      (in_tuser[0]),
    .in_tready      (in_tready),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .triangle_count (count_r),
    .status         (status),
    .cmd            (cmd)
  );

  // table and inside test
  pitm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .safe_x_min   (sx_min_r),
    .safe_x_max   (sx_max_r),
    .safe_y_min   (sy_min_r),
    .safe_y_max   (sy_max_r),
    .cmd          (cmd),
    .status       (status),
    .inside_floor (inside_floor),
    .wall_hit     (wall_hit)
  );

  assign out_tdata = {{(OUT_DATA_W-2){1'b0}}, wall_hit, inside_floor};

endmodule

// ===== bench/point_in_triangle_mesh_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_mesh_test_core_tb
// self-checking bench for the floor triangle point test with wall flag
// ----------------------------------------------------------------------------
// Triangles are loaded and points queried through the input stream. Every
// accepted query is scored by a local integer model of the triangle table,
// search count and safe rectangle unless the directed list fixes its result;
// the result is queued and compared with the result stream in order. A short
// directed list covers the reset state, coordinate extremes, edges, corners,
// degenerate and clockwise triangles, rectangle extremes. Random phases set
// their own registers and use one of three idle patterns on both streams.
// ----------------------------------------------------------------------------
module point_in_triangle_mesh_test_core_tb;
  import pitm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LOAD_SETTLE    = 4;
  localparam int TAIL_CYCLES    = 300;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 22;
  localparam int REPORT_LIMIT   = 10;

  // indexes past the register list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    bit inside_floor;
    bit wall_hit;
  } floor_result_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    pitm_item_t             item;
    bit                     typed;
    bit                     exp_inside;
    bit                     exp_wall;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // local copy of the block state
  pitm_tri_t     mesh_tab [MAX_TRIANGLES];
  bit            slot_loaded [MAX_TRIANGLES];
  logic [8:0]    mesh_count = '0;
  coord_t        win_x_lo   = SAFE_X_MIN_RST;
  coord_t        win_x_hi   = SAFE_X_MAX_RST;
  coord_t        win_y_lo   = SAFE_Y_MIN_RST;
  coord_t        win_y_hi   = SAFE_Y_MAX_RST;

  floor_result_t pending_floor_results [$];
  stim_row_t     directed_rows [$];

  int src_idle_pct  = 8;
  int sink_idle_pct = 47;
  int mismatches    = 0;
  int loads_sent    = 0;
  int queries_sent  = 0;
  int reg_writes    = 0;
  int floor_hits    = 0;
  int wall_hits     = 0;

  point_in_triangle_mesh_test_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // floor model
  // ---------------------------------------------------------------------------
  function automatic int sign_of(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // strict inside test with the division replaced by sign checks
  function automatic bit strictly_inside(pitm_tri_t t, coord_t qx, coord_t qy);
    longint ax, ay, bx, by, cx, cy;
    longint e1, e2, e3, e4, dx, dy, den, na, nb, ng;
    int     s;
    ax = $signed(t.ax);
    ay = $signed(t.ay);
    bx = $signed(t.bx);
    by = $signed(t.by);
    cx = $signed(t.cx);
    cy = $signed(t.cy);
    e1  = by - cy;
    e2  = cx - bx;
    e3  = cy - ay;
    e4  = ax - cx;
    dx  = longint'(qx) - cx;
    dy  = longint'(qy) - cy;
    den = e1 * e4 + e2 * (ay - cy);
    na  = e1 * dx + e2 * dy;
    nb  = e3 * dx + e4 * dy;
    ng  = den - na - nb;
    s   = sign_of(den);
    return s != 0 && sign_of(na) == s && sign_of(nb) == s && sign_of(ng) == s;
  endfunction

  function automatic int searched_count();
    return (mesh_count > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(mesh_count);
  endfunction

  function automatic floor_result_t classify_point(coord_t qx, coord_t qy);
    floor_result_t r;
    bit            safe;
    r.inside_floor = 1'b0;
    for (int i = 0; i < searched_count() && !r.inside_floor; i++)
      r.inside_floor = strictly_inside(mesh_tab[i], qx, qy);
    safe = qx > win_x_lo && qx < win_x_hi && qy > win_y_lo && qy < win_y_hi;
    r.wall_hit = !safe && !r.inside_floor;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TRIANGLE_COUNT: mesh_count = val[8:0];
      REG_SAFE_X_MIN:     win_x_lo   = coord_t'(val);
      REG_SAFE_X_MAX:     win_x_hi   = coord_t'(val);
      REG_SAFE_Y_MIN:     win_y_lo   = coord_t'(val);
      REG_SAFE_Y_MAX:     win_y_hi   = coord_t'(val);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int first_unloaded();
    int s;
    s = 0;
    while (s < MAX_TRIANGLES && slot_loaded[s]) s++;
    return s;
  endfunction

  function automatic pitm_item_t noise_item();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[IN_DATA_W-1:0];
  endfunction

  // mostly local triangles of small or wide span, some full range, some degenerate
  function automatic pitm_tri_t random_triangle();
    pitm_tri_t t;
    int        ox, oy, span, shape;
    shape = $urandom_range(9);
    if (shape < 2) begin
      t = {$urandom, $urandom, $urandom};
      return t;
    end
    ox   = spread(30000);
    oy   = spread(30000);
    span = (shape < 5) ? $urandom_range(16, 64) : $urandom_range(64, 4000);
    t.ax = clamp_coord(ox + spread(span));
    t.ay = clamp_coord(oy + spread(span));
    t.bx = clamp_coord(ox + spread(span));
    t.by = clamp_coord(oy + spread(span));
    t.cx = clamp_coord(ox + spread(span));
    t.cy = clamp_coord(oy + spread(span));
    // two equal corners
    if (shape == 2) begin
      t.cx = t.ax;
      t.cy = t.ay;
    end
    // three corners on one horizontal line
    if (shape == 3) begin
      t.by = t.ay;
      t.cy = t.ay;
    end
    return t;
  endfunction

  function automatic pitm_item_t load_item(int slot);
    pitm_item_t item;
    pitm_tri_t  t;
    item = noise_item();
    t    = random_triangle();
    item.slot       = slot[SLOT_W-1:0];
    item.corner_a_x = t.ax;
    item.corner_a_y = t.ay;
    item.corner_b_x = t.bx;
    item.corner_b_y = t.by;
    item.corner_c_x = t.cx;
    item.corner_c_y = t.cy;
    return item;
  endfunction

  // points inside searched triangles, on their corners and edges, on the
  // rectangle bounds, inside the rectangle, or anywhere
  function automatic pitm_item_t query_item();
    pitm_item_t item;
    pitm_tri_t  t;
    int         n, pick, wa, wb, wc;
    item = noise_item();
    n    = searched_count();
    pick = $urandom_range(99);
    if (n > 0)
      t = mesh_tab[$urandom_range(n - 1)];
    if (pick < 50 && n > 0) begin
      wa = $urandom_range(1, 8);
      wb = $urandom_range(1, 8);
      wc = $urandom_range(1, 8);
      item.query_x = clamp_coord((wa * int'(t.ax) + wb * int'(t.bx) + wc * int'(t.cx))
                                 / (wa + wb + wc));
      item.query_y = clamp_coord((wa * int'(t.ay) + wb * int'(t.by) + wc * int'(t.cy))
                                 / (wa + wb + wc));
    end else if (pick < 60 && n > 0) begin
      if ($urandom_range(1)) begin
        item.query_x = t.bx;
        item.query_y = t.by;
      end else begin
        item.query_x = clamp_coord((int'(t.ax) + int'(t.bx)) / 2);
        item.query_y = clamp_coord((int'(t.ay) + int'(t.by)) / 2);
      end
    end else if (pick < 75) begin
      item.query_x = clamp_coord((int'(win_x_lo) + int'(win_x_hi)) / 2 + spread(8));
      item.query_y = clamp_coord((int'(win_y_lo) + int'(win_y_hi)) / 2 + spread(8));
      case ($urandom_range(3))
        0: item.query_x = clamp_coord(int'(win_x_lo) + spread(1));
        1: item.query_x = clamp_coord(int'(win_x_hi) + spread(1));
        2: item.query_y = clamp_coord(int'(win_y_lo) + spread(1));
        default: item.query_y = clamp_coord(int'(win_y_hi) + spread(1));
      endcase
    end else if (pick < 85) begin
      item.query_x = clamp_coord((int'(win_x_lo) + int'(win_x_hi)) / 2 + spread(64));
      item.query_y = clamp_coord((int'(win_y_lo) + int'(win_y_hi)) / 2 + spread(64));
    end
    return item;
  endfunction

  // directed list builders
  function automatic void add_load(int slot, int ax, int ay, int bx, int by,
                                   int cx, int cy);
    stim_row_t row;
    row             = '{kind: ROW_LOAD, default: '0};
    row.item.slot   = slot[SLOT_W-1:0];
    row.item.corner_a_x = coord_t'(ax);
    row.item.corner_a_y = coord_t'(ay);
    row.item.corner_b_x = coord_t'(bx);
    row.item.corner_b_y = coord_t'(by);
    row.item.corner_c_x = coord_t'(cx);
    row.item.corner_c_y = coord_t'(cy);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_query(int x, int y, bit typed = 0, bit ei = 0,
                                    bit ew = 0);
    stim_row_t row;
    row              = '{kind: ROW_QUERY, default: '0};
    row.item.query_x = coord_t'(x);
    row.item.query_y = coord_t'(y);
    row.typed        = typed;
    row.exp_inside   = ei;
    row.exp_wall     = ew;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row         = '{kind: ROW_REG, default: '0};
    row.reg_idx = idx;
    row.reg_val = val[CFG_DATA_W-1:0];
    directed_rows = {directed_rows, row};
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one input transaction, scored against the model (or given its expected result) when it is taken
  task automatic send_item(logic op, pitm_item_t item, bit typed = 0,
                           bit ei = 0, bit ew = 0);
    floor_result_t r;
    pitm_tri_t     t;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      t.ax = item.corner_a_x;
      t.ay = item.corner_a_y;
      t.bx = item.corner_b_x;
      t.by = item.corner_b_y;
      t.cx = item.corner_c_x;
      t.cy = item.corner_c_y;
      mesh_tab[item.slot]    = t;
      slot_loaded[item.slot] = 1'b1;
      loads_sent++;
    end else begin
      if (typed)
        r = '{inside_floor: ei, wall_hit: ew};
      else
        r = classify_point(item.query_x, item.query_y);
      pending_floor_results = {pending_floor_results, r};
      queries_sent++;
    end
  endtask

  // hold the sender until every result is back and a load has settled
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_floor_results.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  // write enable is left high so back-to-back writes keep one assignment a step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic program_regs(int count, coord_t xl, coord_t xh, coord_t yl,
                              coord_t yh);
    drain_results();
    write_reg(REG_TRIANGLE_COUNT, count[CFG_DATA_W-1:0]);
    write_reg(REG_SAFE_X_MIN, xl);
    write_reg(REG_SAFE_X_MAX, xh);
    write_reg(REG_SAFE_Y_MIN, yl);
    write_reg(REG_SAFE_Y_MAX, yh);
    cfg_we <= 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= sink_idle_pct);

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d (t=%0t)", what, want, got, $time);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    floor_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      floor_hits += out_tdata[0];
      wall_hits  += out_tdata[1];
      if (pending_floor_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 0, 1);
      end else begin
        want = pending_floor_results.pop_front();
        if (out_tdata[0] !== want.inside_floor)
          report_mismatch("inside_floor", want.inside_floor, out_tdata[0]);
        if (out_tdata[1] !== want.wall_hit)
          report_mismatch("wall_hit", want.wall_hit, out_tdata[1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles without any transaction
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog expired with %0d results pending", pending_floor_results.size());
    $display("point_in_triangle_mesh_test_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int     cnt, need, slot;
    coord_t xl, xh, yl, yh, a, b;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: empty search, default rectangle
    add_query(0, 0, 1, 0, 1);
    add_query(320, 400, 1, 0, 0);
    add_query(160, 400, 1, 0, 1);
    add_query(-32768, 32767, 1, 0, 1);
    add_query(32767, -32768, 1, 0, 1);
    // counter-clockwise, degenerate, full range and clockwise triangles
    add_load(0, 0, 0, 1600, 0, 0, 1600);
    add_load(1, 0, 0, 800, 800, 1600, 1600);
    add_load(2, -32768, -32768, 32767, -32768, -32768, 32767);
    add_load(3, 2000, 2000, 2000, 3200, 3200, 2000);
    add_reg(REG_TRIANGLE_COUNT, 4);
    add_query(100, 100);
    add_query(800, 0);
    add_query(0, 1600);
    add_query(800, 800);
    add_query(2100, 2100);
    add_query(-20000, -20000);
    add_query(320, 400);
    // inverted rectangle holds no point
    add_reg(REG_SAFE_X_MIN, 32767);
    add_reg(REG_SAFE_X_MAX, -32768);
    add_query(320, 400);
    add_query(5000, 5000);
    // widest rectangle
    add_reg(REG_SAFE_X_MIN, -32768);
    add_reg(REG_SAFE_X_MAX, 32767);
    add_reg(REG_SAFE_Y_MIN, -32768);
    add_reg(REG_SAFE_Y_MAX, 32767);
    add_query(5000, 5000);
    add_query(-32768, 0);
    // writes past the register list change nothing
    add_reg(REG_UNUSED_HI, 0);
    add_reg(REG_UNUSED_LO, 16'hffff);
    add_query(5000, 5000);
    add_reg(REG_TRIANGLE_COUNT, 0);
    add_query(100, 100, 1, 0, 0);

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_REG: begin
          drain_results();
          write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
          cfg_we <= 1'b0;
        end
        ROW_LOAD:
          send_item(OP_LOAD, directed_rows[r].item);
        default:
          send_item(OP_QUERY, directed_rows[r].item, directed_rows[r].typed,
                    directed_rows[r].exp_inside, directed_rows[r].exp_wall);
      endcase
    end

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        src_idle_pct  = 8;
        sink_idle_pct = 47;
      end else if (p < 2 * PHASES / 3) begin
        src_idle_pct  = 47;
        sink_idle_pct = 8;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end

      case (p)
        6:       cnt = MAX_TRIANGLES;
        7:       cnt = 511;
        9:       cnt = 0;
        default: cnt = $urandom_range(1, 12);
      endcase
      need = (cnt > MAX_TRIANGLES) ? MAX_TRIANGLES : cnt;

      // every searched slot is loaded before the count is raised
      while (first_unloaded() < need)
        send_item(OP_LOAD, load_item(first_unloaded()));

      case ($urandom_range(5))
        0: begin
          xl = SAFE_X_MIN_RST;
          xh = SAFE_X_MAX_RST;
          yl = SAFE_Y_MIN_RST;
          yh = SAFE_Y_MAX_RST;
        end
        1: begin
          a  = coord_t'($urandom);
          b  = coord_t'($urandom);
          xl = (a < b) ? a : b;
          xh = (a < b) ? b : a;
          a  = coord_t'($urandom);
          b  = coord_t'($urandom);
          yl = (a < b) ? a : b;
          yh = (a < b) ? b : a;
        end
        2: begin
          xl = 16'sh7fff;
          xh = 16'sh8000;
          yl = coord_t'($urandom);
          yh = coord_t'($urandom);
        end
        3: begin
          xl = 16'sh8000;
          xh = 16'sh7fff;
          yl = 16'sh8000;
          yh = 16'sh7fff;
        end
        4: begin
          xl = coord_t'($urandom);
          xh = xl;
          yl = coord_t'($urandom);
          yh = yl;
        end
        default: begin
          a  = clamp_coord(spread(20000));
          b  = clamp_coord(spread(20000));
          xl = clamp_coord(int'(a) - int'($urandom_range(4000)));
          xh = clamp_coord(int'(a) + int'($urandom_range(4000)));
          yl = clamp_coord(int'(b) - int'($urandom_range(4000)));
          yh = clamp_coord(int'(b) + int'($urandom_range(4000)));
        end
      endcase
      program_regs(cnt, xl, xh, yl, yh);

      // mostly queries, with loads that overwrite searched slots or any slot
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(3) == 0) begin
          if (need > 0 && $urandom_range(9) < 6)
            slot = $urandom_range(need - 1);
          else
            slot = $urandom_range(MAX_TRIANGLES - 1);
          send_item(OP_LOAD, load_item(slot));
        end else begin
          send_item(OP_QUERY, query_item());
        end
      end
    end

    // wind down
    in_tvalid <= 1'b0;
    while (pending_floor_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d loads and %0d queries over %0d register writes",
             loads_sent, queries_sent, reg_writes);
    $display("floor hits seen %0d, wall hits seen %0d, mismatches %0d",
             floor_hits, wall_hits, mismatches);
    if (mismatches == 0 && pending_floor_results.size() == 0)
      $display("point_in_triangle_mesh_test_core regression: pass");
    else
      $display("point_in_triangle_mesh_test_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pitm_pkg.sv
hdl/pitm_ctrl.sv
hdl/pitm_dp.sv
hdl/point_in_triangle_mesh_test_core.sv
bench/point_in_triangle_mesh_test_core_tb.sv
